FILE: rtl/rmth_pkg.sv
// package for the two-heap running median block
// shared constants and sequencer state type; no dependencies
`default_nettype none
package rmth_pkg;

  localparam int unsigned HalfDepthDef = 512;
  localparam int unsigned SampleW      = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_MED_RD,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

FILE: rtl/rmth_ram.sv
// generic single-port-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module rmth_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 512,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: rtl/running_median_two_heaps.sv
// top level of the two-heap running median; uses rmth_pkg and rmth_ram
//
//   channel | handshake                      | fields
//   input   | sample_valid_i / sample_stall_o | sample_i
//   output  | result_valid_o / result_stall_i | median_o accepted_count_o dropped_o
//
// one item at a time. after acceptance the sequencer decides, sifts a replaced top down
// level by level, pushes the old top or the new item up level by level, reads the
// median and then loads the result register; a dropped item loads it directly.
// the next item is taken in the cycle after the result register loads.
// reset clears the sizes and the result valid; heap memories are not cleared.
// a stalled result holds the sequencer in its output state until it is handed off.
`default_nettype none
module running_median_two_heaps #(
  parameter int unsigned HALF_DEPTH = rmth_pkg::HalfDepthDef,
  localparam int unsigned AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1,
  localparam int unsigned SW = $clog2(HALF_DEPTH + 1),
  localparam int unsigned CW = $clog2(2 * HALF_DEPTH + 1),
  localparam int unsigned XW = AW + 2
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               sample_valid_i,
  output logic                    sample_stall_o,
  input  wire logic signed [31:0] sample_i,
  output logic                    result_valid_o,
  input  wire logic               result_stall_i,
  output logic signed [31:0]      median_o,
  output logic        [CW-1:0]    accepted_count_o,
  output logic                    dropped_o
);

  rmth_pkg::state_e state_q, state_d;
  logic [SW-1:0] lsize_q, lsize_d, usize_q, usize_d;
  logic signed [31:0] x_q, x_d, v_q, v_d, m_q, m_d, lc_q, lc_d;
  logic [AW-1:0] i_q, i_d;        // current node
  logic          side_q, side_d;  // heap being sifted: 1 lower (max), 0 upper (min)
  logic          drop_q, drop_d;
  logic          rv_q, rv_d;
  logic signed [31:0] med_q, med_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          rdrop_q, rdrop_d;

  // memory ports, writes go to the heap selected by side_q
  logic               we;
  logic [AW-1:0]      wa, ra;
  logic signed [31:0] wd;
  logic [31:0]        lrd, urd;

  rmth_ram #(.Width(32), .Depth(HALF_DEPTH)) u_lower (
    .clk_i, .we_i(we && side_q), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(lrd));
  rmth_ram #(.Width(32), .Depth(HALF_DEPTH)) u_upper (
    .clk_i, .we_i(we && !side_q), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(urd));

  logic               take, full, eq, swap;
  logic               fit_l, fit_r, mv_l, mv_r, up_mv;
  logic [SW-1:0]      cur_size, other_size;
  logic [XW-1:0]      lidx, ridx;
  logic [AW-1:0]      pidx;
  logic signed [31:0] rd, ltop, utop, best_v;

  function automatic logic above(logic signed [31:0] a, logic signed [31:0] b, logic mx);
    above = mx ? (a > b) : (a < b);
  endfunction

  // decision and sift helpers
  assign take       = sample_valid_i && !sample_stall_o;
  assign full       = (lsize_q == SW'(HALF_DEPTH)) && (usize_q == SW'(HALF_DEPTH));
  assign eq         = (lsize_q == usize_q);
  assign ltop       = $signed(lrd);
  assign utop       = $signed(urd);
  assign swap       = eq ? ((usize_q != '0) && (x_q > utop))
                         : ((lsize_q != '0) && (x_q < ltop));
  assign cur_size   = side_q ? lsize_q : usize_q;
  assign other_size = side_q ? usize_q : lsize_q;
  assign rd         = side_q ? ltop : utop;
  assign lidx       = XW'({i_q, 1'b1});
  assign ridx       = lidx + XW'(1);
  assign pidx       = (i_q - AW'(1)) >> 1;
  assign fit_l      = lidx < XW'(cur_size);
  assign fit_r      = ridx < XW'(cur_size);
  assign mv_l       = above(lc_q, v_q, side_q);
  assign mv_r       = fit_r && above(rd, mv_l ? lc_q : v_q, side_q);
  assign best_v     = mv_r ? rd : lc_q;
  assign up_mv      = above(v_q, rd, side_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmth_pkg::ST_IDLE:     if (take) state_d = full ? rmth_pkg::ST_OUT : rmth_pkg::ST_DECIDE;
      rmth_pkg::ST_DECIDE:   state_d = swap ? rmth_pkg::ST_DN_LEFT : rmth_pkg::ST_UP_CHK;
      rmth_pkg::ST_DN_LEFT:  state_d = fit_l ? rmth_pkg::ST_DN_RIGHT : rmth_pkg::ST_UP_CHK;
      rmth_pkg::ST_DN_RIGHT: state_d = rmth_pkg::ST_DN_CMP;
      rmth_pkg::ST_DN_CMP:   state_d = (mv_l || mv_r) ? rmth_pkg::ST_DN_LEFT
                                                      : rmth_pkg::ST_UP_CHK;
      rmth_pkg::ST_UP_CHK:   state_d = (i_q == '0) ? rmth_pkg::ST_MED_RD : rmth_pkg::ST_UP_CMP;
      rmth_pkg::ST_UP_CMP:   state_d = up_mv ? rmth_pkg::ST_UP_CHK : rmth_pkg::ST_MED_RD;
      rmth_pkg::ST_MED_RD:   state_d = rmth_pkg::ST_OUT;
      rmth_pkg::ST_OUT:      if (!rv_q || !result_stall_i) state_d = rmth_pkg::ST_IDLE;
      default:               state_d = rmth_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    lsize_d = lsize_q; usize_d = usize_q; x_d = x_q; v_d = v_q; m_d = m_q; lc_d = lc_q;
    i_d = i_q; side_d = side_q; drop_d = drop_q;
    rv_d = rv_q; med_d = med_q; cnt_d = cnt_q; rdrop_d = rdrop_q;
    we = 1'b0; wa = i_q; wd = v_q; ra = '0;
    if (rv_q && !result_stall_i) rv_d = 1'b0;
    unique case (state_q)
      rmth_pkg::ST_IDLE: begin
        // both tops are read at address zero while idle
        if (take) begin
          x_d = sample_i;
          drop_d = full;
        end
      end
      rmth_pkg::ST_DECIDE: begin
        v_d = x_q;
        if (swap) begin
          // replace the top of one heap, its old top is pushed into the other
          side_d = !eq;
          m_d = eq ? utop : ltop;
          i_d = '0;
        end else begin
          // plain push, the heap grows as the push starts
          side_d = eq;
          i_d = AW'(eq ? lsize_q : usize_q);
          if (eq) lsize_d = lsize_q + SW'(1);
          else usize_d = usize_q + SW'(1);
        end
      end
      rmth_pkg::ST_DN_LEFT: begin
        if (fit_l) begin
          ra = lidx[AW-1:0];
        end else begin
          // leaf reached: place the item and start the push of the old top
          we = 1'b1;
          side_d = !side_q; v_d = m_q;
          i_d = AW'(other_size);
          if (side_q) usize_d = usize_q + SW'(1);
          else lsize_d = lsize_q + SW'(1);
        end
      end
      rmth_pkg::ST_DN_RIGHT: begin
        lc_d = rd;
        if (fit_r) ra = ridx[AW-1:0];
      end
      rmth_pkg::ST_DN_CMP: begin
        we = 1'b1;
        if (mv_l || mv_r) begin
          // best child moves up, continue below it
          wd = best_v;
          i_d = mv_r ? ridx[AW-1:0] : lidx[AW-1:0];
        end else begin
          side_d = !side_q; v_d = m_q;
          i_d = AW'(other_size);
          if (side_q) usize_d = usize_q + SW'(1);
          else lsize_d = lsize_q + SW'(1);
        end
      end
      rmth_pkg::ST_UP_CHK: begin
        if (i_q == '0) we = 1'b1;
        else ra = pidx;
      end
      rmth_pkg::ST_UP_CMP: begin
        // parent moves down or the item settles here
        we = 1'b1;
        if (up_mv) begin
          wd = rd;
          i_d = pidx;
        end
      end
      rmth_pkg::ST_MED_RD: ;
      rmth_pkg::ST_OUT: begin
        if (!rv_q || !result_stall_i) begin
          rv_d = 1'b1;
          med_d = (lsize_q != '0) ? ltop : '0;
          cnt_d = CW'(lsize_q) + CW'(usize_q);
          rdrop_d = drop_q;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmth_pkg::ST_IDLE;
      lsize_q <= '0; usize_q <= '0; rv_q <= 1'b0;
      x_q <= '0; v_q <= '0; m_q <= '0; lc_q <= '0; i_q <= '0; side_q <= 1'b0;
      drop_q <= 1'b0; med_q <= '0; cnt_q <= '0; rdrop_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lsize_q <= lsize_d; usize_q <= usize_d; rv_q <= rv_d;
      x_q <= x_d; v_q <= v_d; m_q <= m_d; lc_q <= lc_d; i_q <= i_d; side_q <= side_d;
      drop_q <= drop_d; med_q <= med_d; cnt_q <= cnt_d; rdrop_q <= rdrop_d;
    end
  end

  // outputs
  assign sample_stall_o   = (state_q != rmth_pkg::ST_IDLE);
  assign result_valid_o   = rv_q;
  assign median_o         = med_q;
  assign accepted_count_o = cnt_q;
  assign dropped_o        = rdrop_q;

endmodule
`default_nettype wire
